// ===== rtl/barometric_sensor_compensation_macros.svh =====
// Assertion macros for the RTL of the barometer compensation block.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH
`ifndef SYNTHESIS
`define BSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bsc assertion failed");
`define BSC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("bsc assertion failed");
`else
`define BSC_ASSERT(lbl, prop)
`define BSC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/bsc_pkg.sv =====
package bsc_pkg;

  localparam int LIMB_W  = 32;
  localparam int MUL_LAT = 5;

  localparam int CFG_W = 48;

  localparam int D_W   = 25;
  localparam int N_W   = 61;
  localparam int C3_W  = 34;
  localparam int C2_W  = 88;
  localparam int C1_W  = 147;
  localparam int C0_W  = 205;
  localparam int H3_W  = N_W + C3_W;
  localparam int H2_W  = H3_W + 1;
  localparam int H2P_W = N_W + H2_W;
  localparam int H1_W  = H2P_W + 1;
  localparam int H1P_W = N_W + H1_W;
  localparam int S_W   = H1P_W + 2;

  localparam int T_SHIFT = 32;
  localparam int P_LSB   = 175;
  localparam int P_MSB   = 198;
  localparam int P_HALF  = 174;

  // Accept register, three front stages, three multiplier passes with their adds,
  // and the output register.
  localparam int PIPE_LAT = 5 + 3 * (MUL_LAT + 1);

  typedef enum logic [1:0] {
    CFG_TEMP    = 2'd0,
    CFG_PRESS_A = 2'd1,
    CFG_PRESS_B = 2'd2,
    CFG_PRESS_C = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [23:0] raw_temperature;
    logic [23:0] raw_pressure;
  } in_req_t;

  typedef struct packed {
    logic signed [23:0] temperature_out;
    logic [23:0]        pressure_out;
    logic               saturated;
  } out_res_t;

endpackage

// ===== rtl/bsc_mul.sv =====
module bsc_mul #(
  parameter int WA = 61,
  parameter int WB = 34
) (
  input  logic                  clk,
  input  logic signed [WA-1:0]  a_i,
  input  logic signed [WB-1:0]  b_i,
  output logic signed [WA+WB-1:0] p_o
);
  import bsc_pkg::*;

  localparam int LA = (WA + LIMB_W - 1) / LIMB_W;
  localparam int LB = (WB + LIMB_W - 1) / LIMB_W;
  localparam int RW = LIMB_W * (LA + 1);
  localparam int TW = LIMB_W * (LA + LB);
  localparam int WP = WA + WB;

  logic [WA-1:0]          abs_a;
  logic [WB-1:0]          abs_b;
  logic [LA*LIMB_W-1:0]   mag_a_r;
  logic [LB*LIMB_W-1:0]   mag_b_r;
  logic [3:0]             neg_r;
  logic [2*LIMB_W-1:0]    pp_r [LB][LA];
  logic [RW-1:0]          ev [LB];
  logic [RW-1:0]          od [LB];
  logic [RW-1:0]          row_r [LB];
  logic [TW-1:0]          tot_nxt;
  logic [TW-1:0]          tot_r;
  logic [WP-1:0]          tot_low;
  logic [WP-1:0]          p_r;

  always_comb begin
    abs_a = a_i[WA-1] ? WA'(-a_i) : WA'(a_i);
    abs_b = b_i[WB-1] ? WB'(-b_i) : WB'(b_i);
  end

  // Within one row the even limb products do not overlap, nor do the odd ones,
  // so a row sum is a single add of two concatenations.
  always_comb begin
    for (int j = 0; j < LB; j++) begin
      ev[j] = '0;
      od[j] = '0;
      for (int i = 0; i < LA; i++) begin
        if ((i & 1) == 0) begin
          ev[j][i*LIMB_W +: 2*LIMB_W] = pp_r[j][i];
        end else begin
          od[j][i*LIMB_W +: 2*LIMB_W] = pp_r[j][i];
        end
      end
    end
  end

  always_comb begin
    tot_nxt = '0;
    for (int j = 0; j < LB; j++) begin
      tot_nxt = tot_nxt + (TW'(row_r[j]) << (j * LIMB_W));
    end
    tot_low = tot_r[WP-1:0];
  end

  always_ff @(posedge clk) begin
    mag_a_r <= (LA*LIMB_W)'(abs_a);
    mag_b_r <= (LB*LIMB_W)'(abs_b);
    neg_r   <= {neg_r[2:0], a_i[WA-1] ^ b_i[WB-1]};
    for (int j = 0; j < LB; j++) begin
      for (int i = 0; i < LA; i++) begin
        pp_r[j][i] <= mag_a_r[i*LIMB_W +: LIMB_W] * mag_b_r[j*LIMB_W +: LIMB_W];
      end
      row_r[j] <= ev[j] + od[j];
    end
    tot_r <= tot_nxt;
    p_r   <= neg_r[3] ? WP'(-tot_low) : tot_low;
  end

  assign p_o = $signed(p_r);

endmodule

// ===== rtl/bsc_dly.sv =====
module bsc_dly #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    sr_r[0] <= d_i;
    for (int k = 1; k < DEPTH; k++) begin
      sr_r[k] <= sr_r[k-1];
    end
  end

  assign q_o = sr_r[DEPTH-1];

endmodule

// ===== rtl/barometric_sensor_compensation.sv =====
// Barometer compensation: a request of one raw temperature and one raw pressure is taken
// in every clock cycle that start is high and busy is low, and its compensated result
// is on out_data with out_valid high for exactly one cycle, in request order. The latency
// is set by the three passes of the pressure polynomial through 5-stage 32x32-limb
// multipliers, each pass needing the previous one's sum.
// The receiver cannot stall the block, so results must be captured when they appear.
// busy is high only during reset. Calibration words may be written only while no
// request is in flight.
`include "barometric_sensor_compensation_macros.svh"

module barometric_sensor_compensation (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  bsc_pkg::in_req_t           in_data,
  output logic                       out_valid,
  output bsc_pkg::out_res_t          out_data,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [bsc_pkg::CFG_W-1:0]  cfg_wdata
);
  import bsc_pkg::*;

  localparam int TQ_W = N_W + 1 - T_SHIFT;

  logic        busy_r;
  logic        in_accept;
  logic [PIPE_LAT-1:0] valid_r;

  logic [39:0] temp_coeffs_r;
  logic [47:0] press_coeffs_a_r;
  logic [47:0] press_coeffs_b_r;
  logic [31:0] press_coeffs_c_r;

  logic [15:0]        t1;
  logic signed [16:0] t2s;
  logic signed [7:0]  t3;
  logic signed [16:0] pm1, pm2;
  logic signed [7:0]  p3, p4, p7, p8, p10, p11;
  logic signed [16:0] p5s, p6s;
  logic signed [15:0] p9;

  // Front stages.
  logic signed [D_W-1:0] d_r;
  logic [23:0]           u_r, u_s2_r;
  logic signed [24:0]    us;
  logic signed [49:0]    dd_r;
  logic signed [41:0]    dt2_r, dt2_s3_r;
  logic [47:0]           u2_r;
  logic signed [48:0]    u2s;
  logic signed [32:0]    up4_r, up3_r, up4_s3_r, up3_s3_r;
  logic signed [41:0]    up2_r, up1_r, up2_s3_r, up1_s3_r;
  logic signed [57:0]    ddt3_r;
  logic [71:0]           u3_r;
  logic signed [56:0]    u2p10_r;
  logic signed [64:0]    u2p9_r, u2p9_s4_r;
  logic signed [N_W-1:0] n_r;
  logic signed [80:0]    u3p11_r;
  logic signed [C3_W-1:0] c3_r;
  logic signed [C2_W-1:0] c2_r;
  logic signed [C1_W-1:0] c1_r;
  logic signed [C0_W-1:0] c0a_r, c0_r;

  // Temperature rounding.
  logic signed [N_W:0]    tv;
  logic signed [TQ_W-1:0] tq;
  logic                   t_ok;
  logic [24:0]            temp_r;
  logic [24:0]            temp_d;

  // Horner passes over the linearized temperature.
  logic [N_W-1:0]          n_d6, n_d12;
  logic [C2_W-1:0]         c2_d;
  logic [C1_W-1:0]         c1_d;
  logic [C0_W-1:0]         c0_d;
  logic signed [H3_W-1:0]  h3;
  logic signed [H2_W-1:0]  h2_r;
  logic signed [H2P_W-1:0] h2p;
  logic signed [H1_W-1:0]  h1_r;
  logic signed [H1P_W-1:0] h1p;
  logic signed [S_W-1:0]   s_r;

  logic     p_neg, p_ovf;
  out_res_t out_nxt, out_r;

  assign in_accept = start && !busy_r;
  assign busy      = busy_r;
  assign out_valid = valid_r[PIPE_LAT-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r           <= 1'b1;
      valid_r          <= '0;
      temp_coeffs_r    <= '0;
      press_coeffs_a_r <= '0;
      press_coeffs_b_r <= '0;
      press_coeffs_c_r <= '0;
    end else begin
      busy_r  <= 1'b0;
      valid_r <= {valid_r[PIPE_LAT-2:0], in_accept};
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TEMP:    temp_coeffs_r    <= cfg_wdata[39:0];
          CFG_PRESS_A: press_coeffs_a_r <= cfg_wdata[47:0];
          CFG_PRESS_B: press_coeffs_b_r <= cfg_wdata[47:0];
          CFG_PRESS_C: press_coeffs_c_r <= cfg_wdata[31:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    t1  = temp_coeffs_r[15:0];
    t2s = $signed({1'b0, temp_coeffs_r[31:16]});
    t3  = $signed(temp_coeffs_r[39:32]);
    pm1 = 17'($signed(press_coeffs_a_r[15:0])) - 17'sd16384;
    pm2 = 17'($signed(press_coeffs_a_r[31:16])) - 17'sd16384;
    p3  = $signed(press_coeffs_a_r[39:32]);
    p4  = $signed(press_coeffs_a_r[47:40]);
    p5s = $signed({1'b0, press_coeffs_b_r[15:0]});
    p6s = $signed({1'b0, press_coeffs_b_r[31:16]});
    p7  = $signed(press_coeffs_b_r[39:32]);
    p8  = $signed(press_coeffs_b_r[47:40]);
    p9  = $signed(press_coeffs_c_r[15:0]);
    p10 = $signed(press_coeffs_c_r[23:16]);
    p11 = $signed(press_coeffs_c_r[31:24]);
    us  = $signed({1'b0, u_r});
    u2s = $signed({1'b0, u2_r});
  end

  always_comb begin
    tv   = (N_W+1)'(n_r) + ((N_W+1)'(1) <<< (T_SHIFT - 1));
    tq   = tv[N_W:T_SHIFT];
    t_ok = (tq[TQ_W-1:23] == {(TQ_W-23){tq[23]}});
  end

  always_ff @(posedge clk) begin
    // Stage 1: offset raw temperature.
    d_r <= $signed({1'b0, in_data.raw_temperature}) - $signed({1'b0, t1, 8'h00});
    u_r <= in_data.raw_pressure;
    // Stage 2: first products.
    dd_r   <= d_r * d_r;
    dt2_r  <= d_r * t2s;
    u2_r   <= u_r * u_r;
    u_s2_r <= u_r;
    up4_r  <= us * p4;
    up3_r  <= us * p3;
    up2_r  <= us * pm2;
    up1_r  <= us * pm1;
    // Stage 3.
    ddt3_r   <= dd_r * t3;
    u3_r     <= u2_r * u_s2_r;
    u2p10_r  <= u2s * p10;
    u2p9_r   <= u2s * p9;
    dt2_s3_r <= dt2_r;
    up4_s3_r <= up4_r;
    up3_s3_r <= up3_r;
    up2_s3_r <= up2_r;
    up1_s3_r <= up1_r;
    // Stage 4: linearized temperature and the Horner coefficients in u.
    n_r       <= (N_W'(dt2_s3_r) <<< 18) + N_W'(ddt3_r);
    u3p11_r   <= $signed({1'b0, u3_r}) * p11;
    c3_r      <= (C3_W'(p8) <<< 22) + C3_W'(up4_s3_r);
    c2_r      <= (C2_W'(p7) <<< 77) + (C2_W'(up3_s3_r) <<< 53);
    c1_r      <= (C1_W'(p6s) <<< 127) + (C1_W'(up2_s3_r) <<< 104)
                 + (C1_W'(u2p10_r) <<< 85);
    c0a_r     <= (C0_W'(p5s) <<< 184) + (C0_W'(up1_s3_r) <<< 161);
    u2p9_s4_r <= u2p9_r;
    // Stage 5.
    c0_r   <= c0a_r + (C0_W'(u2p9_s4_r) <<< 133) + (C0_W'(u3p11_r) <<< 116);
    temp_r <= t_ok ? {tq[23:0], 1'b0}
                   : (tq[TQ_W-1] ? {24'h800000, 1'b1} : {24'h7FFFFF, 1'b1});
    // Horner sums between the multiplier passes.
    h2_r <= H2_W'($signed(c2_d)) + H2_W'(h3);
    h1_r <= H1_W'($signed(c1_d)) + H1_W'(h2p);
    s_r  <= S_W'($signed(c0_d)) + S_W'(h1p) + (S_W'(1) <<< P_HALF);
    out_r <= out_nxt;
  end

  bsc_mul #(.WA(N_W), .WB(C3_W)) u_mul_a (.clk(clk), .a_i(n_r), .b_i(c3_r), .p_o(h3));
  bsc_mul #(.WA(N_W), .WB(H2_W)) u_mul_b (
    .clk(clk), .a_i($signed(n_d6)), .b_i(h2_r), .p_o(h2p));
  bsc_mul #(.WA(N_W), .WB(H1_W)) u_mul_c (
    .clk(clk), .a_i($signed(n_d12)), .b_i(h1_r), .p_o(h1p));

  bsc_dly #(.W(N_W), .DEPTH(MUL_LAT + 1)) u_dly_n1 (.clk(clk), .d_i(n_r), .q_o(n_d6));
  bsc_dly #(.W(N_W), .DEPTH(MUL_LAT + 1)) u_dly_n2 (.clk(clk), .d_i(n_d6), .q_o(n_d12));
  bsc_dly #(.W(C2_W), .DEPTH(MUL_LAT)) u_dly_c2 (.clk(clk), .d_i(c2_r), .q_o(c2_d));
  bsc_dly #(.W(C1_W), .DEPTH(2 * MUL_LAT + 1)) u_dly_c1 (
    .clk(clk), .d_i(c1_r), .q_o(c1_d));
  bsc_dly #(.W(C0_W), .DEPTH(3 * MUL_LAT + 1)) u_dly_c0 (
    .clk(clk), .d_i(c0_r), .q_o(c0_d));
  bsc_dly #(.W(25), .DEPTH(3 * MUL_LAT + 2)) u_dly_t (
    .clk(clk), .d_i(temp_r), .q_o(temp_d));

  always_comb begin
    p_neg = s_r[S_W-1];
    p_ovf = |s_r[S_W-2:P_MSB+1];
    out_nxt.temperature_out = $signed(temp_d[24:1]);
    if (p_neg) begin
      out_nxt.pressure_out = '0;
    end else if (p_ovf) begin
      out_nxt.pressure_out = '1;
    end else begin
      out_nxt.pressure_out = s_r[P_MSB:P_LSB];
    end
    out_nxt.saturated = temp_d[0] || p_neg || p_ovf;
  end

  `BSC_ASSERT(a_out_follows_req, out_valid |-> $past(in_accept, PIPE_LAT))
  `BSC_ASSERT_ALWAYS(a_busy_after_reset, $past(rst_n) |-> !busy)
  `BSC_ASSERT(a_mul_zero, $past(n_r == '0, MUL_LAT) |-> h3 == '0)

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import bsc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = PIPE_LAT + 8;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [23:0] raw_t;
    logic [23:0] raw_p;
    bit          typed;
    out_res_t    res;
  } vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_req_t in_data = '0;
  logic out_valid;
  out_res_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Calibration mirror, updated when the write lands.
  logic [39:0] cal_temp;
  logic [47:0] cal_pa, cal_pb;
  logic [31:0] cal_pc;

  out_res_t expected_results[$];
  bit typed_valid = 1'b0;
  out_res_t typed_res;
  int mismatches = 0;
  int cycles = 0;
  bit no_gaps = 1'b0;

  barometric_sensor_compensation u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic out_res_t compensate(logic [23:0] raw_t, logic [23:0] raw_p);
    longint t1, t2, t3, d, n, tv;
    wide_t wn, wu, s;
    out_res_t r;
    t1 = longint'(cal_temp[15:0]);
    t2 = longint'(cal_temp[31:16]);
    t3 = longint'($signed(cal_temp[39:32]));
    d = longint'(raw_t) - t1 * 256;
    n = d * t2 * 262144 + d * d * t3;
    tv = (n + 64'sd2147483648) >>> 32;
    r.saturated = 1'b0;
    if (tv > 8388607) begin
      tv = 8388607;
      r.saturated = 1'b1;
    end else if (tv < -8388608) begin
      tv = -8388608;
      r.saturated = 1'b1;
    end
    r.temperature_out = tv[23:0];
    wn = n;
    wu = longint'(raw_p);
    s = (wide_t'(longint'(cal_pb[15:0])) << 184)
      + ((wide_t'(longint'(cal_pb[31:16])) * wn) << 127)
      + ((wide_t'(longint'($signed(cal_pb[39:32]))) * wn * wn) << 77)
      + ((wide_t'(longint'($signed(cal_pb[47:40]))) * wn * wn * wn) << 22)
      + ((wide_t'(longint'($signed(cal_pa[15:0])) - 16384) * wu) << 161)
      + ((wide_t'(longint'($signed(cal_pa[31:16])) - 16384) * wu * wn) << 104)
      + ((wide_t'(longint'($signed(cal_pa[39:32]))) * wu * wn * wn) << 53)
      + (wide_t'(longint'($signed(cal_pa[47:40]))) * wu * wn * wn * wn)
      + ((wide_t'(longint'($signed(cal_pc[15:0]))) * wu * wu) << 133)
      + ((wide_t'(longint'($signed(cal_pc[23:16]))) * wu * wu * wn) << 85)
      + ((wide_t'(longint'($signed(cal_pc[31:24]))) * wu * wu * wu) << 116)
      + (wide_t'(1) << 174);
    if (s[255]) begin
      r.pressure_out = '0;
      r.saturated = 1'b1;
    end else if (|s[254:199]) begin
      r.pressure_out = '1;
      r.saturated = 1'b1;
    end else begin
      r.pressure_out = s[198:175];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("barometric_sensor_compensation verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_res_t e;
    if (!rst_n) begin
      cal_temp <= '0;
      cal_pa <= '0;
      cal_pb <= '0;
      cal_pc <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TEMP:    cal_temp <= cfg_wdata[39:0];
          CFG_PRESS_A: cal_pa <= cfg_wdata[47:0];
          CFG_PRESS_B: cal_pb <= cfg_wdata[47:0];
          CFG_PRESS_C: cal_pc <= cfg_wdata[31:0];
          default: ;
        endcase
      end
      if (start && !busy)
        expected_results.push_back(typed_valid ? typed_res :
                                   compensate(in_data.raw_temperature, in_data.raw_pressure));
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          e = expected_results.pop_front();
          if (out_data.temperature_out !== e.temperature_out ||
              out_data.pressure_out !== e.pressure_out ||
              out_data.saturated !== e.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected t=%0d p=%0d sat=%0d, got t=%0d p=%0d sat=%0d",
                       e.temperature_out, e.pressure_out, e.saturated,
                       out_data.temperature_out, out_data.pressure_out, out_data.saturated);
          end
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_reading(logic [23:0] raw_t, logic [23:0] raw_p, bit typed,
                              out_res_t res);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_data <= '{raw_temperature: raw_t, raw_pressure: raw_p};
    typed_valid <= typed;
    typed_res <= res;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain_requests();
    start <= 1'b0;
    typed_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // The write enable drops for a cycle between writes.
  task automatic write_cal(cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  // Coefficients that keep most pressures inside the output range.
  task automatic write_mild_cal();
    write_cal(CFG_TEMP, CFG_W'({8'($urandom), 16'($urandom_range(18000, 22000)),
                                16'($urandom_range(25000, 29000))}));
    write_cal(CFG_PRESS_A, {8'($urandom), 8'($urandom), 16'(16384 + $urandom_range(0, 64)),
                            16'(16384 + $urandom_range(0, 64))});
    write_cal(CFG_PRESS_B, {8'($urandom), 8'($urandom), 16'($urandom_range(0, 512)),
                            16'($urandom_range(0, 32767))});
    write_cal(CFG_PRESS_C, CFG_W'({8'($urandom), 8'($urandom),
                                   16'($urandom_range(0, 255))}));
  endtask

  task automatic random_phase(int count, bit near_t1);
    logic [23:0] rt, rp;
    out_res_t none;
    none = '0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (near_t1 && $urandom_range(0, 9) != 0) begin
        rt = {cal_temp[15:0], 8'h00} + 24'($urandom_range(0, 2000000)) - 24'd1000000;
        rp = 24'($urandom_range(0, 16000));
      end else begin
        rt = 24'($urandom);
        rp = 24'($urandom);
      end
      send_reading(rt, rp, 1'b0, none);
    end
    no_gaps = 1'b0;
  endtask

  vec_t directed[] = '{
    '{24'h000000, 24'h000000, 1'b1, '{24'sd0, 24'd0, 1'b0}},
    '{24'hFFFFFF, 24'h000000, 1'b1, '{24'sd0, 24'd0, 1'b0}},
    '{24'h000000, 24'h000001, 1'b1, '{24'sd0, 24'd0, 1'b1}},
    '{24'hFFFFFF, 24'hFFFFFF, 1'b1, '{24'sd0, 24'd0, 1'b1}},
    '{24'h800000, 24'h800000, 1'b1, '{24'sd0, 24'd0, 1'b1}},
    '{24'h555555, 24'hAAAAAA, 1'b1, '{24'sd0, 24'd0, 1'b1}},
    '{24'h000000, 24'h000000, 1'b0, '{24'sd0, 24'd0, 1'b0}},
    '{24'hFFFFFF, 24'hFFFFFF, 1'b0, '{24'sd0, 24'd0, 1'b0}},
    '{24'h000000, 24'hFFFFFF, 1'b0, '{24'sd0, 24'd0, 1'b0}},
    '{24'hFFFFFF, 24'h000000, 1'b0, '{24'sd0, 24'd0, 1'b0}},
    '{24'h6B6C00, 24'h000100, 1'b0, '{24'sd0, 24'd0, 1'b0}},
    '{24'h123456, 24'h654321, 1'b0, '{24'sd0, 24'd0, 1'b0}}
  };

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // With all calibration words at zero the results follow directly.
    for (int i = 0; i < 6; i++)
      send_reading(directed[i].raw_t, directed[i].raw_p, directed[i].typed, directed[i].res);
    drain_requests();

    // Extreme calibration: every register bit set, then a mixed pattern.
    write_cal(CFG_TEMP, '1);
    write_cal(CFG_PRESS_A, '1);
    write_cal(CFG_PRESS_B, '1);
    write_cal(CFG_PRESS_C, '1);
    for (int i = 6; i < directed.size(); i++)
      send_reading(directed[i].raw_t, directed[i].raw_p, 1'b0, directed[i].res);
    drain_requests();
    write_cal(CFG_TEMP, 48'h0000_8000_FFFF);
    write_cal(CFG_PRESS_A, 48'h7F80_7FFF_8000);
    write_cal(CFG_PRESS_B, 48'h807F_FFFF_0000);
    write_cal(CFG_PRESS_C, 48'hFFFF_807F_7FFF);
    for (int i = 6; i < directed.size(); i++)
      send_reading(directed[i].raw_t, directed[i].raw_p, 1'b0, directed[i].res);
    drain_requests();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 2 == 0) begin
        write_mild_cal();
      end else begin
        write_cal(CFG_TEMP, rand48());
        write_cal(CFG_PRESS_A, rand48());
        write_cal(CFG_PRESS_B, rand48());
        write_cal(CFG_PRESS_C, rand48());
      end
      random_phase(115, ph % 2 == 0);
      drain_requests();
    end

    if (mismatches == 0) begin
      $display("barometric_sensor_compensation verification clean");
    end else begin
      $display("barometric_sensor_compensation verification failed");
    end
    $finish;
  end

endmodule
